// ----- sv/prck_pkg.sv -----
// ----------------------------------------------------------------------------
// prck_pkg
// Shared constants, the front-to-back queue entry and k-mer helper functions
// for the packed read canonical k-mer extractor.
// ----------------------------------------------------------------------------
package prck_pkg;

  localparam int KMER_W         = 64;
  localparam int K_MAX          = KMER_W / 2;
  localparam int K_W            = 6;
  localparam int BYTE_W         = 8;
  localparam int LEN_W          = 32;
  localparam int BASES_PER_BYTE = 4;
  localparam int BASE_W         = 2;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_K_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMP_TABLE = 2'd1;

  localparam logic [K_W-1:0]    K_RESET    = 6'd31;
  localparam logic [BYTE_W-1:0] COMP_RESET = 8'd78;

  // front-to-back queue
  localparam int FQ_DEPTH = 4;
  localparam int FQ_PTR_W = 2;
  localparam int FQ_CNT_W = 3;

  // result queue
  localparam int OQ_DEPTH = 2;
  localparam int OQ_CNT_W = 2;

  typedef struct packed {
    logic [BYTE_W-1:0]         data;   // packed bases, first in bits 7:6
    logic [BASES_PER_BYTE-1:0] valid;  // base is inside the read
    logic [BASES_PER_BYTE-1:0] emit;   // base completes a k-mer
    logic                      fresh;  // first byte of a record
  } entry_t;

  function automatic logic [K_W-1:0] eff_k(input logic [K_W-1:0] k);
    logic [K_W-1:0] r;
    r = k;
    if (k == '0) r = K_W'(1);
    if (k > K_W'(K_MAX)) r = K_W'(K_MAX);
    return r;
  endfunction

  function automatic logic [KMER_W-1:0] kmask(input logic [K_W-1:0] k);
    logic [KMER_W-1:0] m;
    if (k >= K_W'(K_MAX)) m = '1;
    else m = (KMER_W'(1) << {k, 1'b0}) - KMER_W'(1);
    return m;
  endfunction

endpackage

// ----- sv/packed_read_canonical_kmer_extractor_top.sv -----
// ----------------------------------------------------------------------------
// packed_read_canonical_kmer_extractor_top
// Extracts canonical 2-bit k-mers from a byte stream of packed reads.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   input    | push / full          | data_byte[7:0]
//   result   | pop / empty          | canonical_kmer[63:0], last_of_byte
//   config   | cfg_valid/cfg_ready  | cfg_index[1:0], cfg_data[7:0]
//
// A byte is taken each cycle while the 4-entry parse queue has room. Header
// and length bytes feed only the parser; a base byte is rolled base by base,
// each base inside the read (up to 4), by the single k-mer rolling unit. Its
// results pass the parse queue, byte register and result queue. Reset clears
// parser state and queues; configuration returns to k = 31 and complement
// table 78. A full result queue stalls only emitting bases.
// ----------------------------------------------------------------------------
module packed_read_canonical_kmer_extractor_top import prck_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [BYTE_W-1:0]    data_byte,
  input  logic                 push,
  output logic                 full,
  output logic [KMER_W-1:0]    canonical_kmer,
  output logic                 last_of_byte,
  output logic                 empty,
  input  logic                 pop,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  logic [K_W-1:0]    k_size;
  logic [BYTE_W-1:0] comp_table;
  logic [K_W-1:0]    k_eff;
  logic              q_empty, q_pop;
  entry_t            q_head;

  assign cfg_ready = 1'b1;
  assign k_eff     = eff_k(k_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      k_size     <= K_RESET;
      comp_table <= COMP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_K_SIZE:     k_size     <= cfg_data[K_W-1:0];
        CFG_COMP_TABLE: comp_table <= cfg_data;
        default: ;
      endcase
    end
  end

  prck_front u_front (
    .clk       (clk),
    .rst       (rst),
    .data_byte (data_byte),
    .push      (push),
    .full      (full),
    .k_eff     (k_eff),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  prck_back u_back (
    .clk            (clk),
    .rst            (rst),
    .k_eff          (k_eff),
    .comp_table     (comp_table),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .canonical_kmer (canonical_kmer),
    .last_of_byte   (last_of_byte),
    .empty          (empty),
    .pop            (pop)
  );

endmodule

// ----- sv/prck_front.sv -----
// ----------------------------------------------------------------------------
// prck_front
// Byte parser: walks block headers, record lengths and base bytes, and queues
// one entry per base byte with its valid and emit masks.
// ----------------------------------------------------------------------------
module prck_front import prck_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              push,
  output logic              full,
  input  logic [K_W-1:0]    k_eff,
  output logic              q_empty,
  output entry_t            q_head,
  input  logic              q_pop
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_BASES  = 2'd2;

  logic [1:0]       phase, phase_next;
  logic [1:0]       fbc, fbc_next;
  logic [LEN_W-1:0] bbl, bbl_next;
  logic [LEN_W-1:0] rlen, rlen_next;
  logic [LEN_W-1:0] bleft, bleft_next;
  logic [K_W-1:0]   taken, taken_next;
  logic             fresh, fresh_next;

  logic             accept;
  logic             q_push;
  logic [LEN_W-1:0] bbl_dec;
  logic [LEN_W-1:0] byte_sh;
  entry_t           ent;

  entry_t              fq [FQ_DEPTH];
  logic [FQ_PTR_W-1:0] wptr, rptr;
  logic [FQ_CNT_W-1:0] cnt;

  assign full    = (cnt == FQ_CNT_W'(FQ_DEPTH));
  assign q_empty = (cnt == '0);
  assign q_head  = fq[rptr];
  assign accept  = push && !full;
  assign q_push  = accept && (phase == PH_BASES);
  assign bbl_dec = bbl - LEN_W'(1);
  assign byte_sh = LEN_W'(data_byte) << {fbc, 3'b000};

  always_comb begin
    ent.data  = data_byte;
    ent.fresh = fresh;
    for (int i = 0; i < BASES_PER_BYTE; i++) begin
      ent.valid[i] = bleft > LEN_W'(i);
      ent.emit[i]  = ent.valid[i] &&
                     (({1'b0, taken} + (K_W + 1)'(i + 1)) >= {1'b0, k_eff});
    end
  end

  always_comb begin
    phase_next = phase;
    fbc_next   = fbc;
    bbl_next   = bbl;
    rlen_next  = rlen;
    bleft_next = bleft;
    taken_next = taken;
    fresh_next = fresh;
    case (phase)
      PH_LENGTH: begin
        rlen_next = ((fbc == 2'd0) ? '0 : rlen) | byte_sh;
        fbc_next  = fbc + 2'd1;
        if (fbc == 2'd3) begin
          taken_next = '0;
          fresh_next = 1'b1;
          bleft_next = rlen_next[LEN_W-1] ? '0 : rlen_next;
          if (!rlen_next[LEN_W-1] && rlen_next != '0) phase_next = PH_BASES;
        end
        bbl_next = bbl_dec;
        if (bbl_dec == '0) begin
          phase_next = PH_HEADER;
          fbc_next   = 2'd0;
        end
      end
      PH_BASES: begin
        bleft_next = bleft - LEN_W'(BASES_PER_BYTE);
        taken_next = (taken >= K_W'(K_MAX - BASES_PER_BYTE)) ? K_W'(K_MAX)
                                                             : taken + K_W'(BASES_PER_BYTE);
        fresh_next = 1'b0;
        fbc_next   = 2'd0;
        if (bleft <= LEN_W'(BASES_PER_BYTE)) phase_next = PH_LENGTH;
        bbl_next = bbl_dec;
        if (bbl_dec == '0) phase_next = PH_HEADER;
      end
      default: begin
        phase_next = PH_HEADER;
        bbl_next   = ((fbc == 2'd0) ? '0 : bbl) | byte_sh;
        fbc_next   = fbc + 2'd1;
        if (fbc == 2'd3 && bbl_next != '0) phase_next = PH_LENGTH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      fbc   <= '0;
      bbl   <= '0;
      rlen  <= '0;
      bleft <= '0;
      taken <= '0;
      fresh <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      fbc   <= fbc_next;
      bbl   <= bbl_next;
      rlen  <= rlen_next;
      bleft <= bleft_next;
      taken <= taken_next;
      fresh <= fresh_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) fq[wptr] <= ent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (q_push) wptr <= wptr + FQ_PTR_W'(1);
      if (q_pop)  rptr <= rptr + FQ_PTR_W'(1);
      if (q_push && !q_pop)      cnt <= cnt + FQ_CNT_W'(1);
      else if (!q_push && q_pop) cnt <= cnt - FQ_CNT_W'(1);
    end
  end

endmodule

// ----- sv/prck_back.sv -----
// ----------------------------------------------------------------------------
// prck_back
// Rolls the forward and reverse-complement k-mers one base per cycle, but an
// emitting base waits for result queue room, and queues its canonical k-mer.
// ----------------------------------------------------------------------------
module prck_back import prck_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [K_W-1:0]    k_eff,
  input  logic [BYTE_W-1:0] comp_table,
  input  logic              q_empty,
  input  entry_t            q_head,
  output logic              q_pop,
  output logic [KMER_W-1:0] canonical_kmer,
  output logic              last_of_byte,
  output logic              empty,
  input  logic              pop
);

  entry_t            cur;
  logic              cur_ok;
  logic [1:0]        idx;
  logic [KMER_W-1:0] fwd, rev;

  logic [KMER_W-1:0] oq_kmer [OQ_DEPTH];
  logic              oq_last [OQ_DEPTH];
  logic              owp, orp;
  logic [OQ_CNT_W-1:0] ocnt;

  logic [BYTE_W-1:0] data_sh;
  logic [BASE_W-1:0] base, comp;
  logic [BYTE_W-1:0] comp_sh;
  logic [KMER_W-1:0] mask, fbase, rbase, fwd_roll, rev_roll, canon;
  logic [BASES_PER_BYTE-1:0] emit_hi;
  logic [1:0]        idx_inc;
  logic              is_last, need_out, oq_pop, oq_room, step, done_item, oq_push;

  assign data_sh  = cur.data << {idx, 1'b0};
  assign base     = data_sh[BYTE_W-1 -: BASE_W];
  assign comp_sh  = comp_table >> {base, 1'b0};
  assign comp     = comp_sh[BASE_W-1:0];
  assign mask     = kmask(k_eff);
  assign fbase    = (cur.fresh && idx == 2'd0) ? '0 : fwd;
  assign rbase    = (cur.fresh && idx == 2'd0) ? '0 : rev;
  assign fwd_roll = {fbase[KMER_W-3:0], base} & mask;
  assign rev_roll = ({2'b00, rbase[KMER_W-1:2]} |
                     (KMER_W'(comp) << {k_eff - K_W'(1), 1'b0})) & mask;
  assign canon    = (fwd_roll < rev_roll) ? fwd_roll : rev_roll;

  assign idx_inc  = idx + 2'd1;
  assign emit_hi  = cur.emit >> ({1'b0, idx} + 3'd1);
  assign is_last  = (emit_hi == '0);
  assign need_out = cur.emit[idx];

  assign empty    = (ocnt == '0);
  assign oq_pop   = pop && !empty;
  assign oq_room  = (ocnt < OQ_CNT_W'(OQ_DEPTH)) || oq_pop;
  // a base that emits waits for room in the result queue
  assign step      = cur_ok && (!need_out || oq_room);
  assign done_item = step && (idx == 2'd3 || !cur.valid[idx_inc]);
  assign q_pop     = !q_empty && (!cur_ok || done_item);
  assign oq_push   = step && need_out;

  assign canonical_kmer = oq_kmer[orp];
  assign last_of_byte   = oq_last[orp];

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_ok <= 1'b0;
      idx    <= '0;
    end else if (q_pop) begin
      cur_ok <= 1'b1;
      idx    <= '0;
    end else if (done_item) begin
      cur_ok <= 1'b0;
    end else if (step) begin
      idx <= idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_head;
    if (step) begin
      fwd <= fwd_roll;
      rev <= rev_roll;
    end
    if (oq_push) begin
      oq_kmer[owp] <= canon;
      oq_last[owp] <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= 1'b0;
      orp  <= 1'b0;
      ocnt <= '0;
    end else begin
      if (oq_push) owp <= !owp;
      if (oq_pop)  orp <= !orp;
      if (oq_push && !oq_pop)      ocnt <= ocnt + OQ_CNT_W'(1);
      else if (!oq_push && oq_pop) ocnt <= ocnt - OQ_CNT_W'(1);
    end
  end

endmodule

// ----- sv/prck_checker.sv -----
// ----------------------------------------------------------------------------
// prck_checker
// Port-level checks for the canonical k-mer extractor, bound to the top level.
// ----------------------------------------------------------------------------
module prck_checker import prck_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 full,
  input logic [KMER_W-1:0]    canonical_kmer,
  input logic                 last_of_byte,
  input logic                 empty,
  input logic                 pop,
  input logic                 cfg_valid,
  input logic                 cfg_ready
);

  // both queues come out of reset drained
  a_reset_drained: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full))
    else $error("queues not drained after reset");

  // a waiting result holds until it is transferred
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(canonical_kmer) && $stable(last_of_byte)))
    else $error("waiting result changed before transfer");

  // a waiting result carries known values
  a_result_known: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !$isunknown({canonical_kmer, last_of_byte}))
    else $error("waiting result has unknown bits");

  // configuration writes are never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind packed_read_canonical_kmer_extractor_top prck_checker u_prck_checker (.*);
